>>> src/rttc_pkg.sv
// rttc_pkg: shared types for the rational to tick count converter
// used by rttc_unit and rational_to_tick_count_top
package rttc_pkg;

    localparam int W = 64;
    localparam int CNT_W = 7;

    typedef struct packed {
        logic [W-1:0] duration_numerator;
        logic [W-1:0] duration_denominator;
        logic [W-1:0] quantum_numerator;
        logic [W-1:0] quantum_denominator;
    } in_t;

    typedef struct packed {
        logic         ok;
        logic [W-1:0] tick_count;
    } out_t;

    typedef enum logic {
        OP_DIV,
        OP_MUL
    } op_t;

    typedef struct packed {
        logic         start;
        op_t          op;
        logic [W-1:0] a;
        logic [W-1:0] b;
    } req_t;

    typedef struct packed {
        logic         busy;
        logic         done;
        logic [W-1:0] quo;
        logic [W-1:0] acc;
        logic         ovf;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GCD_TEST,
        S_GCD_WAIT,
        S_RED_X,
        S_RED_Y,
        S_SCALE,
        S_MUL_DIV,
        S_MUL_PROD,
        S_QUO,
        S_DONE
    } state_t;

endpackage

>>> src/rttc_unit.sv
// rttc_unit: shared bit-serial unit, 64-bit restoring divide or checked multiply
// one result bit per cycle; depends on rttc_pkg
module rttc_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  rttc_pkg::req_t req,
    output rttc_pkg::rsp_t rsp
);
    import rttc_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    op_t              op_reg, op_next;
    logic [W-1:0]     x_reg, x_next;
    logic [W-1:0]     y_reg, y_next;
    logic [W:0]       acc_reg, acc_next;
    logic             ovf_reg, ovf_next;

    logic [W:0] rem_sh;
    logic [W:0] mul_sh;
    logic       ge;

    always_comb
    begin
        rem_sh = {acc_reg[W-1:0], x_reg[W-1]};
        ge     = rem_sh >= {1'b0, y_reg};
        mul_sh = {acc_reg[W-1:0], 1'b0} + (x_reg[W-1] ? {1'b0, y_reg} : {(W+1){1'b0}});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
            op_next   = req.op;
            x_next    = req.a;
            y_next    = req.b;
            acc_next  = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_DIV:
                begin
                    acc_next = ge ? (rem_sh - {1'b0, y_reg}) : rem_sh;
                    x_next   = {x_reg[W-2:0], ge};
                end
                OP_MUL:
                begin
                    // sticky overflow: any bit pushed past bit 63 is lost for good
                    ovf_next = ovf_reg | acc_reg[W-1] | mul_sh[W];
                    acc_next = {1'b0, mul_sh[W-1:0]};
                    x_next   = {x_reg[W-2:0], 1'b0};
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        ovf_reg <= ovf_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = x_reg;
    assign rsp.acc  = acc_reg[W-1:0];
    assign rsp.ovf  = ovf_reg;

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("unit started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("done without a running operation");

    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("running with an empty bit count");

endmodule

>>> src/rational_to_tick_count_top.sv
// rational_to_tick_count_top: reduces two 64-bit fractions and divides them into ticks
// depends on rttc_pkg and rttc_unit
//
//   channel   signals                          direction
//   in        in_valid/in_ready, in_data       beat in: the two fractions
//   out       out_valid/out_ready, out_data    beat out: ok and tick_count
//   cfg       cfg_we, cfg_wdata                max_tick_scale write
//
// every divide and multiply runs on one bit-serial unit
// per item: the euclid divides of the four gcds, 8 reduction divides, then two multiplies and a divide
// a zero duration denominator, quantum numerator or quantum denominator is rejected; in_ready is high only while idle
// rst_n clears control, max_tick_scale resets to all ones
// a held result waits in the output register while the next beat is accepted
module rational_to_tick_count_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rttc_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output rttc_pkg::out_t out_data,
    input  logic           cfg_we,
    input  logic [63:0]    cfg_wdata
);
    import rttc_pkg::*;

    state_t       state_reg, state_next;
    logic [1:0]   phase_reg, phase_next;
    logic [W-1:0] n_reg, n_next, d_reg, d_next, qn_reg, qn_next, qd_reg, qd_next;
    logic [W-1:0] ga_reg, ga_next, gb_reg, gb_next, g_reg, g_next;
    logic [W-1:0] div_reg, div_next;
    logic [W-1:0] scale_reg;
    logic         res_ok_reg, res_ok_next;
    logic [W-1:0] res_tick_reg, res_tick_next;
    logic         out_valid_reg, out_valid_next;
    out_t         out_reg, out_next;

    req_t         req;
    rsp_t         rsp;
    logic [W-1:0] x_sel, y_sel;
    logic         in_fire;

    rttc_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // pair reduced in each phase: (n,d) (qn,qd) (n,qn) (qd,d)
    always_comb
    begin
        case (phase_reg)
            2'd0:    begin x_sel = n_reg;  y_sel = d_reg;  end
            2'd1:    begin x_sel = qn_reg; y_sel = qd_reg; end
            2'd2:    begin x_sel = n_reg;  y_sel = qn_reg; end
            default: begin x_sel = qd_reg; y_sel = d_reg;  end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        qn_next        = qn_reg;
        qd_next        = qd_reg;
        ga_next        = ga_reg;
        gb_next        = gb_reg;
        g_next         = g_reg;
        div_next       = div_reg;
        res_ok_next    = res_ok_reg;
        res_tick_next  = res_tick_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        req.start      = 1'b0;
        req.op         = OP_DIV;
        req.a          = ga_reg;
        req.b          = gb_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    n_next        = in_data.duration_numerator;
                    d_next        = in_data.duration_denominator;
                    qn_next       = in_data.quantum_numerator;
                    qd_next       = in_data.quantum_denominator;
                    ga_next       = in_data.duration_numerator;
                    gb_next       = in_data.duration_denominator;
                    phase_next    = 2'd0;
                    res_ok_next   = 1'b0;
                    res_tick_next = '0;
                    if (in_data.duration_denominator == '0 ||
                        in_data.quantum_numerator == '0 ||
                        in_data.quantum_denominator == '0)
                        state_next = S_DONE;
                    else
                        state_next = S_GCD_TEST;
                end
            end
            S_GCD_TEST:
            begin
                req.start = 1'b1;
                if (gb_reg == '0)
                begin
                    g_next     = ga_reg;
                    req.a      = x_sel;
                    req.b      = ga_reg;
                    state_next = S_RED_X;
                end
                else
                begin
                    state_next = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT:
            begin
                if (rsp.done)
                begin
                    ga_next    = gb_reg;
                    gb_next    = rsp.acc;
                    state_next = S_GCD_TEST;
                end
            end
            S_RED_X:
            begin
                if (rsp.done)
                begin
                    case (phase_reg)
                        2'd0:    n_next  = rsp.quo;
                        2'd1:    qn_next = rsp.quo;
                        2'd2:    n_next  = rsp.quo;
                        default: qd_next = rsp.quo;
                    endcase
                    req.start  = 1'b1;
                    req.a      = y_sel;
                    req.b      = g_reg;
                    state_next = S_RED_Y;
                end
            end
            S_RED_Y:
            begin
                if (rsp.done)
                begin
                    case (phase_reg)
                        2'd0:
                        begin
                            d_next  = rsp.quo;
                            ga_next = qn_reg;
                            gb_next = qd_reg;
                        end
                        2'd1:
                        begin
                            qd_next = rsp.quo;
                            ga_next = n_reg;
                            gb_next = qn_reg;
                        end
                        2'd2:
                        begin
                            qn_next = rsp.quo;
                            ga_next = qd_reg;
                            gb_next = d_reg;
                        end
                        default: d_next = rsp.quo;
                    endcase
                    phase_next = phase_reg + 2'd1;
                    state_next = (phase_reg == 2'd3) ? S_SCALE : S_GCD_TEST;
                end
            end
            S_SCALE:
            begin
                if (qn_reg > scale_reg || qd_reg > scale_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    req.start  = 1'b1;
                    req.op     = OP_MUL;
                    req.a      = d_reg;
                    req.b      = qn_reg;
                    state_next = S_MUL_DIV;
                end
            end
            S_MUL_DIV:
            begin
                if (rsp.done)
                begin
                    if (rsp.ovf || rsp.acc == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        div_next   = rsp.acc;
                        req.start  = 1'b1;
                        req.op     = OP_MUL;
                        req.a      = n_reg;
                        req.b      = qd_reg;
                        state_next = S_MUL_PROD;
                    end
                end
            end
            S_MUL_PROD:
            begin
                if (rsp.done)
                begin
                    if (rsp.ovf)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        req.start  = 1'b1;
                        req.a      = rsp.acc;
                        req.b      = div_reg;
                        state_next = S_QUO;
                    end
                end
            end
            S_QUO:
            begin
                if (rsp.done)
                begin
                    res_ok_next   = (rsp.acc == '0);
                    res_tick_next = (rsp.acc == '0) ? rsp.quo : '0;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next      = 1'b1;
                    out_next.ok         = res_ok_reg;
                    out_next.tick_count = res_tick_reg;
                    state_next          = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
            scale_reg     <= '1;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                scale_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        d_reg        <= d_next;
        qn_reg       <= qn_next;
        qd_reg       <= qd_next;
        ga_reg       <= ga_next;
        gb_reg       <= gb_next;
        g_reg        <= g_next;
        div_reg      <= div_next;
        res_ok_reg   <= res_ok_next;
        res_tick_reg <= res_tick_next;
        out_reg      <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.ok |-> out_data.tick_count == '0)
        else $error("tick_count nonzero on a rejected beat");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != S_IDLE)
        else $error("accepted beat did not start work");

    a_wait_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GCD_WAIT || state_reg == S_QUO) && !rsp.done |-> rsp.busy)
        else $error("waiting on an idle unit");

endmodule
